// File: src/padm_pkg.sv
package padm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int LIMIT_BITS      = 8;
    localparam int DEADBAND_BITS   = 12;
    localparam int TALLY_BITS      = 9;
    localparam int SUM_EXTRA_BITS  = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = DEADBAND_BITS;

    localparam logic [LIMIT_BITS-1:0]    LIMIT_RESET    = LIMIT_BITS'(100);
    localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = DEADBAND_BITS'(15);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PEAK_COUNT_LIMIT = 2'd0,
        REG_DEADBAND         = 2'd1
    } cfg_reg_t;

endpackage

// File: src/peak_average_deadband_meter.sv
// Peak / average meter with deadband on converter samples.
// Input channel: in_valid/in_ready with adc_sample, one word per sample.
// Output channel: out_valid/out_ready with stable_level and level_updated;
// exactly one output word per input word, in order.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
// peak_count_limit (0) or deadband (1); other indexes are dropped.
// Write config only while the block is idle.
// An ordinary sample passes the queue register and the output register on
// its way out. A sample that closes an averaging window runs a bit-serial
// divide of the SAMPLE_BITS+8 bit sum in the back end before its word shows;
// throughput is one word per cycle otherwise, while out_ready stays high.
// A 2-entry queue between front and back absorbs input while the divider
// runs; the front keeps taking samples until it fills.
// When out_ready is low while a word is offered, the output register holds it
// and the back end takes no new job; the queue then fills and in_ready drops.
// Reset clears peak, sum, tally and level to zero, limit to 100, deadband to 15.
module peak_average_deadband_meter #(
    parameter int SAMPLE_BITS = padm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              adc_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [SAMPLE_BITS-1:0]              stable_level,
    output logic                                level_updated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [padm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [padm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import padm_pkg::*;

    localparam int JOB_W = 1 + SAMPLE_BITS + SUM_EXTRA_BITS + TALLY_BITS;

    logic [LIMIT_BITS-1:0]    limit_reg;
    logic [DEADBAND_BITS-1:0] deadband_reg;

    logic             fq_valid, fq_ready;
    logic [JOB_W-1:0] fq_data;
    logic             qb_valid, qb_ready;
    logic [JOB_W-1:0] qb_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            deadband_reg <= DEADBAND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PEAK_COUNT_LIMIT: limit_reg    <= cfg_data[LIMIT_BITS-1:0];
                REG_DEADBAND:         deadband_reg <= cfg_data[DEADBAND_BITS-1:0];
                default:              ;
            endcase
        end
    end

    padm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .adc_sample       (adc_sample),
        .peak_count_limit (limit_reg),
        .job_valid        (fq_valid),
        .job_ready        (fq_ready),
        .job_data         (fq_data)
    );

    padm_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    padm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (qb_valid),
        .job_ready     (qb_ready),
        .job_data      (qb_data),
        .deadband      (deadband_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .stable_level  (stable_level),
        .level_updated (level_updated)
    );

endmodule

// File: src/padm_front.sv
module padm_front #(
    parameter int SAMPLE_BITS = padm_pkg::SAMPLE_BITS_DEF,
    parameter int JOB_W       = 1 + SAMPLE_BITS + padm_pkg::SUM_EXTRA_BITS
                                + padm_pkg::TALLY_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SAMPLE_BITS-1:0]           adc_sample,
    input  logic [padm_pkg::LIMIT_BITS-1:0]  peak_count_limit,
    output logic                             job_valid,
    input  logic                             job_ready,
    output logic [JOB_W-1:0]                 job_data
);
    import padm_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + SUM_EXTRA_BITS;

    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [TALLY_BITS-1:0]  tally_reg, tally_next;

    logic [SAMPLE_BITS-1:0] peak_upd;
    logic                   is_zero;
    logic [SUM_W-1:0]       sum_acc;
    logic [TALLY_BITS-1:0]  tally_acc;
    logic                   avg_go;

    always_comb
    begin
        peak_upd  = (adc_sample > peak_reg) ? adc_sample : peak_reg;
        is_zero   = (adc_sample == '0);
        sum_acc   = is_zero ? (sum_reg + SUM_W'(peak_upd)) : sum_reg;
        tally_acc = is_zero ? (tally_reg + TALLY_BITS'(1)) : tally_reg;
        avg_go    = (tally_acc > TALLY_BITS'(peak_count_limit)) && (tally_acc != '0);

        peak_next  = is_zero ? '0 : peak_upd;
        sum_next   = avg_go ? '0 : sum_acc;
        tally_next = avg_go ? '0 : tally_acc;
    end

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign job_data  = {avg_go, sum_acc, tally_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            sum_reg   <= '0;
            tally_reg <= '0;
        end
        else if (in_valid && job_ready)
        begin
            peak_reg  <= peak_next;
            sum_reg   <= sum_next;
            tally_reg <= tally_next;
        end
    end

endmodule

// File: src/padm_queue.sv
module padm_queue #(
    parameter int JOB_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [JOB_W-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [JOB_W-1:0] pop_data
);
    import padm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [JOB_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");
`endif

endmodule

// File: src/padm_back.sv
module padm_back #(
    parameter int SAMPLE_BITS = padm_pkg::SAMPLE_BITS_DEF,
    parameter int JOB_W       = 1 + SAMPLE_BITS + padm_pkg::SUM_EXTRA_BITS
                                + padm_pkg::TALLY_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  logic [JOB_W-1:0]                   job_data,
    input  logic [padm_pkg::DEADBAND_BITS-1:0] deadband,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [SAMPLE_BITS-1:0]             stable_level,
    output logic                               level_updated
);
    import padm_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + SUM_EXTRA_BITS;
    localparam int CNT_W = $clog2(SUM_W);
    localparam int CMP_W = (SAMPLE_BITS > DEADBAND_BITS) ? SAMPLE_BITS : DEADBAND_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [SUM_W-1:0]       quot_reg;
    logic [TALLY_BITS-1:0]  rem_reg;
    logic [TALLY_BITS-1:0]  divisor_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SAMPLE_BITS-1:0] held_reg;
    logic                   out_valid_reg;
    logic                   updated_reg;

    logic                   job_avg;
    logic [SUM_W-1:0]       job_sum;
    logic [TALLY_BITS-1:0]  job_tally;
    logic                   slot_free;
    logic [TALLY_BITS:0]    rem_shift;
    logic                   rem_ge;
    logic [TALLY_BITS:0]    rem_sub;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   keep_old;
    logic                   load_word;

    assign {job_avg, job_sum, job_tally} = job_data;
    assign slot_free = !out_valid_reg || out_ready;
    assign job_ready = (state_reg == ST_IDLE) && slot_free;

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[SUM_W-1]};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        avg       = quot_reg[SAMPLE_BITS-1:0];
        diff      = (avg > held_reg) ? (avg - held_reg) : (held_reg - avg);
        keep_old  = (CMP_W'(diff) < CMP_W'(deadband));
        // a new output word is loaded for a plain sample or a finished average
        load_word = slot_free && (((state_reg == ST_IDLE) && job_valid && !job_avg)
                                  || (state_reg == ST_DONE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            updated_reg   <= 1'b0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            divisor_reg   <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (load_word)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid && slot_free)
                    begin
                        if (job_avg)
                        begin
                            quot_reg    <= job_sum;
                            rem_reg     <= '0;
                            divisor_reg <= job_tally;
                            count_reg   <= CNT_W'(SUM_W - 1);
                            state_reg   <= ST_DIV;
                        end
                        else
                        begin
                            updated_reg   <= 1'b0;
                        end
                    end
                end
                ST_DIV:
                begin
                    quot_reg <= {quot_reg[SUM_W-2:0], rem_ge};
                    rem_reg  <= rem_ge ? rem_sub[TALLY_BITS-1:0] : rem_shift[TALLY_BITS-1:0];
                    count_reg <= count_reg - CNT_W'(1);
                    if (count_reg == '0)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        if (!keep_old)
                            held_reg <= avg;
                        updated_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign stable_level  = held_reg;
    assign level_updated = updated_reg;

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> divisor_reg != '0)
        else $error("divide started with zero tally");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> (quot_reg >> SAMPLE_BITS) == '0)
        else $error("average exceeds sample range");

    a_held_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != $past(held_reg) |-> out_valid_reg && updated_reg)
        else $error("level moved without an update word");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import padm_pkg::*;

    localparam int SB      = SAMPLE_BITS_DEF;
    localparam int SUMW    = SB + SUM_EXTRA_BITS;
    localparam int TIMEOUT = 500000;
    localparam int DRAIN_CYCLES = 32;

    // indexes past the two registers; the block must drop these writes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [SB-1:0] level;
        logic          updated;
    } meter_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  val;
        logic                      typed;
        logic [SB-1:0]             level;
        logic                      upd;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [SB-1:0]             adc_sample = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [SB-1:0]             stable_level;
    logic                      level_updated;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    peak_average_deadband_meter #(.SAMPLE_BITS(SB)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .adc_sample    (adc_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .stable_level  (stable_level),
        .level_updated (level_updated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // meter model state and register copies
    logic [LIMIT_BITS-1:0]    lim_cfg  = LIMIT_RESET;
    logic [DEADBAND_BITS-1:0] band_cfg = DEADBAND_RESET;
    logic [SB-1:0]            pk       = '0;
    logic [SUMW-1:0]          pk_sum   = '0;
    logic [TALLY_BITS-1:0]    pk_tally = '0;
    logic [SB-1:0]            lvl      = '0;

    meter_word_t level_q[$];
    int          mismatches = 0;
    int          snd_idle = 29;
    int          rcv_idle = 66;

    // typed expectation for the word being offered, set by the stimulus loop
    logic          row_typed = 1'b0;
    logic [SB-1:0] row_level = '0;
    logic          row_upd = 1'b0;

    row_t dir_tab [0:24] = '{
        '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b1, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd2048, 1'b1, 12'd0, 1'b0},
        '{ROW_CFG, REG_PEAK_COUNT_LIMIT, 12'd0, 1'b0, 12'd0, 1'b0},
        '{ROW_CFG, REG_DEADBAND, 12'd0, 1'b0, 12'd0, 1'b0},
        '{ROW_CFG, REG_SPARE_A, 12'd4095, 1'b0, 12'd0, 1'b0},
        '{ROW_CFG, REG_SPARE_B, 12'd4095, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b1, 12'd3071, 1'b1},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 12'd3071, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b1, 12'd4095, 1'b1},
        '{ROW_SAMPLE, '0, 12'd1, 1'b1, 12'd4095, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b1, 12'd1, 1'b1},
        '{ROW_CFG, REG_PEAK_COUNT_LIMIT, 12'd1, 1'b0, 12'd0, 1'b0},
        '{ROW_CFG, REG_DEADBAND, 12'd4095, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd3000, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd1000, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b0, 12'd0, 1'b0},
        '{ROW_CFG, REG_DEADBAND, 12'd2, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd5, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b0, 12'd0, 1'b0},
        '{ROW_CFG, REG_PEAK_COUNT_LIMIT, 12'hFFF, 1'b0, 12'd0, 1'b0},
        '{ROW_CFG, REG_DEADBAND, 12'd15, 1'b0, 12'd0, 1'b0},
        '{ROW_SAMPLE, '0, 12'd0, 1'b0, 12'd0, 1'b0}
    };

    function automatic meter_word_t meter_step(input logic [SB-1:0] s);
        meter_word_t   w;
        logic [SUMW-1:0] quot;
        logic [SB-1:0]   avg;
        logic [SB-1:0]   diff;
        w.updated = 1'b0;
        if (s > pk)
            pk = s;
        if (s == '0)
        begin
            pk_sum   = pk_sum + SUMW'(pk);
            pk       = '0;
            pk_tally = pk_tally + 1'b1;
        end
        if (pk_tally > TALLY_BITS'(lim_cfg) && pk_tally != '0)
        begin
            quot     = pk_sum / SUMW'(pk_tally);
            avg      = quot[SB-1:0];
            diff     = (avg > lvl) ? avg - lvl : lvl - avg;
            pk_sum   = '0;
            pk_tally = '0;
            if (!(diff < band_cfg))
                lvl = avg;
            w.updated = 1'b1;
        end
        w.level = lvl;
        return w;
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin : monitor
        meter_word_t w;
        meter_word_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PEAK_COUNT_LIMIT: lim_cfg = cfg_data[LIMIT_BITS-1:0];
                    REG_DEADBAND:         band_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                w = meter_step(adc_sample);
                if (row_typed)
                begin
                    w.level   = row_level;
                    w.updated = row_upd;
                end
                level_q.push_back(w);
            end
            if (out_valid && out_ready)
            begin
                got.level   = stable_level;
                got.updated = level_updated;
                if (level_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected word: level %0d updated %0b",
                                 got.level, got.updated);
                    mismatches++;
                end
                else
                begin
                    w = level_q.pop_front();
                    if (got !== w)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: level exp %0d got %0d, updated exp %0b got %0b",
                                     w.level, got.level, w.updated, got.updated);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        repeat (TIMEOUT) @(posedge clk);
        $display("** peak_average_deadband_meter: FAILED **");
        $finish;
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_sample(input logic [SB-1:0] s);
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= s;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (level_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int            sent;
        int            len;
        int            amp;
        logic [7:0]    lim_new;
        logic [11:0]   band_new;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end
            else
            begin
                row_typed = dir_tab[i].typed;
                row_level = dir_tab[i].level;
                row_upd   = dir_tab[i].upd;
                send_sample(dir_tab[i].val[SB-1:0]);
            end
        end
        row_typed = 1'b0;

        for (int ph = 0; ph < 3; ph++)
        begin
            snd_idle = (ph == 0) ? 29 : (ph == 1) ? 66 : 0;
            rcv_idle = (ph == 0) ? 66 : (ph == 1) ? 29 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                if (ph == 0 && blk == 0)
                begin
                    lim_new  = 8'd0;
                    band_new = 12'd4095;
                end
                else if (ph == 1 && blk == 0)
                begin
                    lim_new  = 8'd255;
                    band_new = 12'd0;
                end
                else
                begin
                    case ($urandom_range(7))
                        0:       lim_new = 8'd0;
                        1:       lim_new = 8'd255;
                        default: lim_new = 8'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(3))
                        0:       band_new = 12'd0;
                        1:       band_new = 12'd4095;
                        2:       band_new = 12'($urandom_range(0, 63));
                        default: band_new = 12'($urandom_range(0, 4095));
                    endcase
                end
                drain_results();
                // junk in the upper data bits must not reach the limit
                write_reg(REG_PEAK_COUNT_LIMIT, {4'($urandom_range(15)), lim_new});
                write_reg(REG_DEADBAND, band_new);
                sent = 0;
                while (sent < 100)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_sample(SB'($urandom_range(0, 4095)));
                        sent++;
                    end
                    else
                    begin
                        // half cycle: some samples, the peak, then the zero crossing
                        case ($urandom_range(2))
                            0:       amp = 4095;
                            1:       amp = $urandom_range(1, 4095);
                            default: amp = int'(lvl) + $urandom_range(0, 40);
                        endcase
                        if (amp > 4095)
                            amp = 4095;
                        if (amp < 1)
                            amp = 1;
                        len = $urandom_range(0, 4);
                        repeat (len) send_sample(SB'($urandom_range(1, amp)));
                        send_sample(SB'(amp));
                        send_sample('0);
                        sent += len + 2;
                    end
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && level_q.size() == 0)
            $display("** peak_average_deadband_meter: PASSED **");
        else
            $display("** peak_average_deadband_meter: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
src/padm_pkg.sv
src/padm_front.sv
src/padm_queue.sv
src/padm_back.sv
src/peak_average_deadband_meter.sv
tb/tb_top.sv
